// ===== rtl/core/csfr_pkg.sv =====
package csfr_pkg;

  localparam int DEF_MAX_ROWS = 64;
  localparam int DEF_MAX_COLS = 64;

  localparam int CFG_W  = 7;
  localparam int SPAN_W = 13;
  localparam int LIM_W  = 11;

  localparam logic [7:0]       DOT_CODE     = 8'd46;
  localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  typedef enum logic [1:0] {
    REQ_FILL  = 2'd0,
    REQ_CLEAR = 2'd1,
    REQ_READ  = 2'd2,
    REQ_NOP   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    SHP_RECT    = 2'd0,
    SHP_UP      = 2'd1,
    SHP_DOWN    = 2'd2,
    SHP_DIAMOND = 2'd3
  } shape_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FILL,
    ST_RD_ISSUE,
    ST_RD_DATA,
    ST_DONE
  } state_t;

endpackage

// ===== rtl/core/csfr_ram.sv =====
module csfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/clipped_shape_fill_raster_core.sv =====
// Character canvas of MAX_ROWS x MAX_COLS 8-bit cells, one canvas row per
// memory entry. Each input word is one request: fill a clipped shape with a
// brush code, clear the canvas to '.', read one cell, or do nothing.
// Every request gives exactly one output word (cell value, done flag).
//
// Input channel: in_valid / in_stall; a word is taken while the block is idle.
// Output channel: out_valid / out_stall; the result sits in an output register
// so the next request can start while the previous result waits.
// Configuration: cfg_we, cfg_index (0 active rows, 1 active columns),
// cfg_wdata; write only while the block is idle.
//
// A fill walks the active rows, one row read, merged and written back per
// cycle through the single read port; a clear sweeps all MAX_ROWS rows. A
// fill with a negative origin or no active rows writes no row. Requests do
// not overlap.
// Reset is synchronous: after rst_n releases, a sweep writes '.' into every
// row; in_stall stays high during it.
// A stalled output word holds; a finished request waits until the output
// register is free, with in_stall high.
module clipped_shape_fill_raster_core #(
  parameter int MAX_ROWS = csfr_pkg::DEF_MAX_ROWS,
  parameter int MAX_COLS = csfr_pkg::DEF_MAX_COLS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_wdata,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [1:0]  in_shape_kind,
  input  logic signed [7:0] in_origin_x,
  input  logic signed [7:0] in_origin_y,
  input  logic [6:0]  in_shape_width,
  input  logic [6:0]  in_shape_height,
  input  logic [7:0]  in_brush_code,
  input  logic [5:0]  in_read_row,
  input  logic [5:0]  in_read_col,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_cell_value,
  output logic        out_request_done
);

  import csfr_pkg::*;

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CLW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int CW  = $clog2(MAX_ROWS + 1);
  localparam int DW  = MAX_COLS * 8;
  localparam logic [LIM_W-1:0] MAXR_L = LIM_W'(MAX_ROWS);
  localparam logic [LIM_W-1:0] MAXC_L = LIM_W'(MAX_COLS);
  localparam logic [CW-1:0]    LAST_ROW = CW'(MAX_ROWS - 1);

  state_t state_r, state_nxt;

  logic [CFG_W-1:0] rows_r, rows_nxt;
  logic [CFG_W-1:0] cols_r, cols_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             owed_r, owed_nxt;

  logic [1:0]        kind_r, kind_nxt;
  logic signed [7:0] x_r, x_nxt;
  logic signed [7:0] y_r, y_nxt;
  logic [6:0]        w_r, w_nxt;
  logic [6:0]        h_r, h_nxt;
  logic [7:0]        brush_r, brush_nxt;
  logic [5:0]        rrow_r, rrow_nxt;
  logic [5:0]        rcol_r, rcol_nxt;
  logic              rd_ok_r, rd_ok_nxt;
  logic [7:0]        res_r, res_nxt;

  logic                     p1_valid_r, p1_valid_nxt;
  logic [RW-1:0]            p1_row_r, p1_row_nxt;
  logic                     p1_hit_r, p1_hit_nxt;
  logic signed [SPAN_W-1:0] p1_lo_r, p1_lo_nxt;
  logic signed [SPAN_W-1:0] p1_hi_r, p1_hi_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_value_r, out_value_nxt;

  logic [LIM_W-1:0] rows_l, cols_l, nr_l, nc_l;
  logic [CW-1:0]    nr;
  logic             accept, out_free, fill_go;

  logic signed [SPAN_W-1:0] rs, xs, ys, hs, ws, dd, ee, half;
  logic                     hit;
  logic signed [SPAN_W-1:0] lo, hi;

  logic          ram_we;
  logic [RW-1:0] ram_waddr, ram_raddr;
  logic [DW-1:0] ram_wdata, ram_rdata, merged;
  logic [LIM_W-1:0] rrow_l, rcol_l;
  logic [CLW-1:0]   col_idx;

  assign rows_l = LIM_W'(rows_r);
  assign cols_l = LIM_W'(cols_r);
  assign nr_l   = (rows_l > MAXR_L) ? MAXR_L : rows_l;
  assign nc_l   = (cols_l > MAXC_L) ? MAXC_L : cols_l;
  assign nr     = nr_l[CW-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign fill_go  = !in_origin_x[7] && !in_origin_y[7] && (nr != '0);

  assign rrow_l  = LIM_W'(in_read_row);
  assign rcol_l  = LIM_W'(in_read_col);
  assign col_idx = CLW'(rcol_r);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (cnt_r == LAST_ROW) begin
          state_nxt = owed_r ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          priority case (in_req_type)
            REQ_FILL:  state_nxt = fill_go ? ST_FILL : ST_DONE;
            REQ_CLEAR: state_nxt = ST_CLEAR;
            REQ_READ:  state_nxt = ST_RD_ISSUE;
            default:   state_nxt = ST_DONE;
          endcase
        end
      end
      ST_FILL: begin
        if (cnt_r == nr - CW'(1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_RD_ISSUE: state_nxt = ST_RD_DATA;
      ST_RD_DATA:  state_nxt = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // row span of the shape for the row being issued
  always_comb begin
    rs   = $signed({{(SPAN_W - CW){1'b0}}, cnt_r});
    xs   = SPAN_W'(x_r);
    ys   = SPAN_W'(y_r);
    hs   = $signed({{(SPAN_W - 7){1'b0}}, h_r});
    ws   = $signed({{(SPAN_W - 7){1'b0}}, w_r});
    dd   = rs - ys;
    ee   = ys + (hs <<< 1) - rs;
    half = dd;
    hit  = 1'b0;
    lo   = xs;
    hi   = xs;
    unique case (kind_r)
      SHP_RECT: begin
        hit = (rs >= ys) && (rs < ys + hs);
        hi  = xs + ws - SPAN_W'(1);
      end
      SHP_UP: begin
        half = dd;
        hit  = !dd[SPAN_W-1] && (dd < hs);
      end
      SHP_DOWN: begin
        half = -dd;
        hit  = !half[SPAN_W-1] && (half < hs);
      end
      default: begin
        if (!dd[SPAN_W-1] && (dd <= hs)) begin
          half = dd;
          hit  = 1'b1;
        end else begin
          half = ee;
          hit  = !ee[SPAN_W-1] && (ee < hs);
        end
      end
    endcase
    if (kind_r != SHP_RECT) begin
      lo = xs - half;
      hi = xs + half;
    end
  end

  // merge brush into the row read back from the canvas
  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      if (p1_hit_r && (SPAN_W'(c) >= p1_lo_r) && (SPAN_W'(c) <= p1_hi_r) &&
          (LIM_W'(c) < nc_l)) begin
        merged[c*8 +: 8] = brush_r;
      end else begin
        merged[c*8 +: 8] = ram_rdata[c*8 +: 8];
      end
    end
  end

  // memory port control
  always_comb begin
    ram_raddr = (state_r == ST_RD_ISSUE) ? RW'(rrow_r) : cnt_r[RW-1:0];
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_r[RW-1:0];
      ram_wdata = {MAX_COLS{DOT_CODE}};
    end else begin
      ram_we    = p1_valid_r;
      ram_waddr = p1_row_r;
      ram_wdata = merged;
    end
  end

  // outputs and datapath
  always_comb begin
    rows_nxt      = rows_r;
    cols_nxt      = cols_r;
    cnt_nxt       = cnt_r;
    owed_nxt      = owed_r;
    kind_nxt      = kind_r;
    x_nxt         = x_r;
    y_nxt         = y_r;
    w_nxt         = w_r;
    h_nxt         = h_r;
    brush_nxt     = brush_r;
    rrow_nxt      = rrow_r;
    rcol_nxt      = rcol_r;
    rd_ok_nxt     = rd_ok_r;
    res_nxt       = res_r;
    p1_valid_nxt  = 1'b0;
    p1_row_nxt    = cnt_r[RW-1:0];
    p1_hit_nxt    = hit;
    p1_lo_nxt     = lo;
    p1_hi_nxt     = hi;
    out_valid_nxt = out_valid_r && out_stall;
    out_value_nxt = out_value_r;

    if (cfg_we) begin
      unique case (cfg_index)
        CFG_ROWS: rows_nxt = cfg_wdata;
        CFG_COLS: cols_nxt = cfg_wdata;
        default:  rows_nxt = rows_r;
      endcase
    end

    unique case (state_r)
      ST_CLEAR: begin
        cnt_nxt = cnt_r + CW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt   = '0;
          owed_nxt  = 1'b1;
          kind_nxt  = in_shape_kind;
          x_nxt     = in_origin_x;
          y_nxt     = in_origin_y;
          w_nxt     = in_shape_width;
          h_nxt     = in_shape_height;
          brush_nxt = in_brush_code;
          rrow_nxt  = in_read_row;
          rcol_nxt  = in_read_col;
          rd_ok_nxt = (rrow_l < nr_l) && (rcol_l < nc_l);
          res_nxt   = '0;
        end
      end
      ST_FILL: begin
        cnt_nxt      = cnt_r + CW'(1);
        p1_valid_nxt = 1'b1;
      end
      ST_RD_ISSUE: begin
        cnt_nxt = cnt_r;
      end
      ST_RD_DATA: begin
        if (rd_ok_r) begin
          res_nxt = ram_rdata[{col_idx, 3'b000} +: 8];
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = res_r;
          owed_nxt      = 1'b0;
        end
      end
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      rows_r      <= ACTIVE_RESET;
      cols_r      <= ACTIVE_RESET;
      cnt_r       <= '0;
      owed_r      <= 1'b0;
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      cnt_r       <= cnt_nxt;
      owed_r      <= owed_nxt;
      p1_valid_r  <= p1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    x_r         <= x_nxt;
    y_r         <= y_nxt;
    w_r         <= w_nxt;
    h_r         <= h_nxt;
    brush_r     <= brush_nxt;
    rrow_r      <= rrow_nxt;
    rcol_r      <= rcol_nxt;
    rd_ok_r     <= rd_ok_nxt;
    res_r       <= res_nxt;
    p1_row_r    <= p1_row_nxt;
    p1_hit_r    <= p1_hit_nxt;
    p1_lo_r     <= p1_lo_nxt;
    p1_hi_r     <= p1_hi_nxt;
    out_value_r <= out_value_nxt;
  end

  csfr_ram #(
    .WIDTH (DW),
    .DEPTH (MAX_ROWS),
    .AW    (RW)
  ) u_canvas (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid        = out_valid_r;
  assign out_cell_value   = out_value_r;
  assign out_request_done = 1'b1;

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !p1_valid_r)
    else $error("row write pending while idle");

  a_write_in_fill: assert property (@(posedge clk) disable iff (!rst_n)
    p1_valid_r |-> (state_r == ST_FILL || state_r == ST_DONE))
    else $error("row write outside a fill");

  a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r != ST_IDLE)
    else $error("accepted word did not start");

  a_read_order: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RD_DATA |-> $past(state_r) == ST_RD_ISSUE)
    else $error("read data without issue");

  a_done_owed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE |-> owed_r)
    else $error("result without a request");
`endif

endmodule
